/* rtl/shw_pkg.sv */
// ----------------------------------------------------------------------------
// shw_pkg
// Shared types, codes and constants of the sensor health watchdog.
// ----------------------------------------------------------------------------
package shw_pkg;

    localparam int NUM_SENSORS = 2;
    localparam int SENS_LIDAR  = 0;
    localparam int SENS_IMU    = 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REQ_LIDAR   = 3'd0;
    localparam logic [2:0] REQ_IMU     = 3'd1;
    localparam logic [2:0] REQ_CHECK   = 3'd2;
    localparam logic [2:0] REQ_RECOVER = 3'd3;
    localparam logic [2:0] REQ_RESET   = 3'd4;

    localparam logic [2:0] REG_TIMEOUT    = 3'd0;
    localparam logic [2:0] REG_FAIL_LIMIT = 3'd1;
    localparam logic [2:0] REG_AUTO_REC   = 3'd2;
    localparam logic [2:0] REG_REC_DELAY  = 3'd3;
    localparam logic [2:0] REG_ACCEL_HIGH = 3'd4;
    localparam logic [2:0] REG_ACCEL_LOW  = 3'd5;

    localparam logic [15:0] RST_TIMEOUT    = 16'd1000;
    localparam logic [7:0]  RST_FAIL_LIMIT = 8'd3;
    localparam logic        RST_AUTO_REC   = 1'b1;
    localparam logic [15:0] RST_REC_DELAY  = 16'd3000;
    localparam logic [14:0] RST_ACCEL_HIGH = 15'd6400;
    localparam logic [14:0] RST_ACCEL_LOW  = 15'd1280;
    localparam logic [29:0] RST_HIGH_SQ    = 30'd40960000;
    localparam logic [29:0] RST_LOW_SQ     = 30'd1638400;

    localparam logic [7:0]  FAIL_MAX    = 8'hFF;
    localparam logic [15:0] ATTEMPT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_HEALTHY    = 3'd0,
        ST_DEGRADED   = 3'd1,
        ST_FAULT      = 3'd2,
        ST_RECOVERING = 3'd3,
        ST_ESTOP      = 3'd4
    } wd_state_t;

    typedef enum logic [2:0] {
        KIND_LIDAR,
        KIND_IMU,
        KIND_CHECK,
        KIND_RECOVER,
        KIND_RESET,
        KIND_NONE
    } req_kind_t;

    typedef struct packed {
        logic [15:0] timeout;
        logic [7:0]  fail_limit;
        logic        auto_rec;
        logic [15:0] rec_delay;
        logic [29:0] high_sq;
        logic [29:0] low_sq;
    } cfg_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [31:0] time_ms;
        logic        fall;
    } item_t;

endpackage

/* rtl/shw_regs.sv */
// ----------------------------------------------------------------------------
// shw_regs
// Configuration registers behind the APB port, with the squared accel limits.
// ----------------------------------------------------------------------------
module shw_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [shw_pkg::ADDR_W-1:0]  paddr,
    input  logic [shw_pkg::DATA_W-1:0]  pwdata,
    output logic [shw_pkg::DATA_W-1:0]  prdata,
    output shw_pkg::cfg_t               cfg
);

    logic [15:0] timeout_reg;
    logic [7:0]  fail_limit_reg;
    logic        auto_rec_reg;
    logic [15:0] rec_delay_reg;
    logic [14:0] accel_high_reg;
    logic [14:0] accel_low_reg;
    logic [29:0] high_sq_reg;
    logic [29:0] low_sq_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= shw_pkg::RST_TIMEOUT;
            fail_limit_reg <= shw_pkg::RST_FAIL_LIMIT;
            auto_rec_reg   <= shw_pkg::RST_AUTO_REC;
            rec_delay_reg  <= shw_pkg::RST_REC_DELAY;
            accel_high_reg <= shw_pkg::RST_ACCEL_HIGH;
            accel_low_reg  <= shw_pkg::RST_ACCEL_LOW;
            high_sq_reg    <= shw_pkg::RST_HIGH_SQ;
            low_sq_reg     <= shw_pkg::RST_LOW_SQ;
        end
        else
        begin
            high_sq_reg <= 30'(accel_high_reg) * 30'(accel_high_reg);
            low_sq_reg  <= 30'(accel_low_reg) * 30'(accel_low_reg);
            if (wr_en)
            begin
                case (reg_idx)
                    shw_pkg::REG_TIMEOUT:    timeout_reg    <= pwdata[15:0];
                    shw_pkg::REG_FAIL_LIMIT: fail_limit_reg <= pwdata[7:0];
                    shw_pkg::REG_AUTO_REC:   auto_rec_reg   <= pwdata[0];
                    shw_pkg::REG_REC_DELAY:  rec_delay_reg  <= pwdata[15:0];
                    shw_pkg::REG_ACCEL_HIGH: accel_high_reg <= pwdata[14:0];
                    shw_pkg::REG_ACCEL_LOW:  accel_low_reg  <= pwdata[14:0];
                    default:                 ;
                endcase
            end
        end
    end

    always_comb
    begin
        case (reg_idx)
            shw_pkg::REG_TIMEOUT:    prdata = {16'd0, timeout_reg};
            shw_pkg::REG_FAIL_LIMIT: prdata = {24'd0, fail_limit_reg};
            shw_pkg::REG_AUTO_REC:   prdata = {31'd0, auto_rec_reg};
            shw_pkg::REG_REC_DELAY:  prdata = {16'd0, rec_delay_reg};
            shw_pkg::REG_ACCEL_HIGH: prdata = {17'd0, accel_high_reg};
            shw_pkg::REG_ACCEL_LOW:  prdata = {17'd0, accel_low_reg};
            default:                 prdata = '0;
        endcase
    end

    assign cfg.timeout    = timeout_reg;
    assign cfg.fail_limit = fail_limit_reg;
    assign cfg.auto_rec   = auto_rec_reg;
    assign cfg.rec_delay  = rec_delay_reg;
    assign cfg.high_sq    = high_sq_reg;
    assign cfg.low_sq     = low_sq_reg;

endmodule

/* rtl/shw_front.sv */
// ----------------------------------------------------------------------------
// shw_front
// Accepts events, decodes the request type and squares the IMU components,
// then classifies the fall test and pushes the item into the queue.
// ----------------------------------------------------------------------------
module shw_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  shw_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic [31:0]        time_ms,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic               q_full,
    output logic               q_push,
    output shw_pkg::item_t     q_item
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    shw_pkg::req_kind_t  s1_kind_reg;
    logic [31:0]         s1_time_reg;
    logic [30:0]         sqx_reg;
    logic [30:0]         sqy_reg;
    logic [30:0]         sqz_reg;
    logic signed [31:0]  prod_x;
    logic signed [31:0]  prod_y;
    logic signed [31:0]  prod_z;
    shw_pkg::req_kind_t  kind;
    logic                load;
    logic [32:0]         sq_sum;

    always_comb
    begin
        case (req_type)
            shw_pkg::REQ_LIDAR:   kind = shw_pkg::KIND_LIDAR;
            shw_pkg::REQ_IMU:     kind = shw_pkg::KIND_IMU;
            shw_pkg::REQ_CHECK:   kind = shw_pkg::KIND_CHECK;
            shw_pkg::REQ_RECOVER: kind = shw_pkg::KIND_RECOVER;
            shw_pkg::REQ_RESET:   kind = shw_pkg::KIND_RESET;
            default:              kind = shw_pkg::KIND_NONE;
        endcase
    end

    assign prod_x = accel_x * accel_x;
    assign prod_y = accel_y * accel_y;
    assign prod_z = accel_z * accel_z;

    assign in_ready = !s1_valid_reg || !q_full;
    assign load     = in_valid && in_ready;
    assign q_push   = s1_valid_reg && !q_full;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_kind_reg <= kind;
            s1_time_reg <= time_ms;
            sqx_reg     <= prod_x[30:0];
            sqy_reg     <= prod_y[30:0];
            sqz_reg     <= prod_z[30:0];
        end
    end

    assign sq_sum = 33'(sqx_reg) + 33'(sqy_reg) + 33'(sqz_reg);

    assign q_item.kind    = s1_kind_reg;
    assign q_item.time_ms = s1_time_reg;
    assign q_item.fall    = (sq_sum > 33'(cfg.high_sq)) || (sq_sum < 33'(cfg.low_sq));

endmodule

/* rtl/shw_queue.sv */
// ----------------------------------------------------------------------------
// shw_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module shw_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  shw_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output shw_pkg::item_t head_item
);

    shw_pkg::item_t                   slot_reg [shw_pkg::QUEUE_DEPTH];
    logic [shw_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [shw_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [shw_pkg::QUEUE_CW-1:0]     count_reg;
    logic [shw_pkg::QUEUE_CW-1:0]     count_next;

    assign full      = (count_reg == shw_pkg::QUEUE_CW'(shw_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + shw_pkg::QUEUE_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - shw_pkg::QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + shw_pkg::QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + shw_pkg::QUEUE_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/shw_back.sv */
// ----------------------------------------------------------------------------
// shw_back
// Applies one queued event per cycle, while the output is not stalled, to the
// watchdog state and holds the result until the output transfer completes.
// ----------------------------------------------------------------------------
module shw_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  shw_pkg::cfg_t  cfg,
    input  logic           q_empty,
    input  shw_pkg::item_t q_item,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [2:0]     wd_state,
    output logic           emergency_active,
    output logic           stop_pulse,
    output logic           health_report,
    output logic           lidar_ok,
    output logic           imu_ok,
    output logic [7:0]     lidar_fail_count,
    output logic [7:0]     imu_fail_count,
    output logic [15:0]    recovery_count,
    output logic           recovery_pending
);

    shw_pkg::wd_state_t state_reg, state_next;
    logic        seen_reg     [shw_pkg::NUM_SENSORS];
    logic        seen_next    [shw_pkg::NUM_SENSORS];
    logic [31:0] last_reg     [shw_pkg::NUM_SENSORS];
    logic [31:0] last_next    [shw_pkg::NUM_SENSORS];
    logic        healthy_reg  [shw_pkg::NUM_SENSORS];
    logic        healthy_next [shw_pkg::NUM_SENSORS];
    logic [7:0]  fail_reg     [shw_pkg::NUM_SENSORS];
    logic [7:0]  fail_next    [shw_pkg::NUM_SENSORS];
    logic [15:0] attempts_reg, attempts_next;
    logic        armed_reg, armed_next;
    logic [31:0] deadline_reg, deadline_next;
    logic        emerg_reg, emerg_next;
    logic        pulse_reg, pulse_next;
    logic        report_reg, report_next;
    logic        out_valid_reg, out_valid_next;

    logic [31:0] now;
    logic [31:0] since_deadline;
    logic [31:0] elapsed;
    logic        all_ok;
    logic        any_bad;
    logic        critical;
    logic        do_trigger;
    logic        do_recover;

    assign q_pop = !q_empty && (!out_valid_reg || out_ready);
    assign now   = q_item.time_ms;

    always_comb
    begin
        state_next    = state_reg;
        seen_next     = seen_reg;
        last_next     = last_reg;
        healthy_next  = healthy_reg;
        fail_next     = fail_reg;
        attempts_next = attempts_reg;
        armed_next    = armed_reg;
        deadline_next = deadline_reg;
        emerg_next    = emerg_reg;
        pulse_next    = 1'b0;
        report_next   = (q_item.kind == shw_pkg::KIND_CHECK);
        any_bad       = 1'b0;
        critical      = 1'b0;
        do_trigger    = 1'b0;
        do_recover    = 1'b0;
        elapsed       = '0;
        all_ok        = 1'b1;

        since_deadline = now - deadline_reg;
        for (int i = 0; i < shw_pkg::NUM_SENSORS; i++)
        begin
            all_ok = all_ok && healthy_reg[i];
        end
        if (armed_reg && !since_deadline[31])
        begin
            armed_next = 1'b0;
            state_next = all_ok ? shw_pkg::ST_HEALTHY : shw_pkg::ST_FAULT;
        end

        case (q_item.kind)
            shw_pkg::KIND_LIDAR:
            begin
                seen_next[shw_pkg::SENS_LIDAR]    = 1'b1;
                last_next[shw_pkg::SENS_LIDAR]    = now;
                healthy_next[shw_pkg::SENS_LIDAR] = 1'b1;
            end
            shw_pkg::KIND_IMU:
            begin
                seen_next[shw_pkg::SENS_IMU]    = 1'b1;
                last_next[shw_pkg::SENS_IMU]    = now;
                healthy_next[shw_pkg::SENS_IMU] = 1'b1;
                do_trigger = q_item.fall;
            end
            shw_pkg::KIND_CHECK:
            begin
                for (int i = 0; i < shw_pkg::NUM_SENSORS; i++)
                begin
                    elapsed = now - last_reg[i];
                    if (seen_reg[i])
                    begin
                        if (elapsed > 32'(cfg.timeout))
                        begin
                            healthy_next[i] = 1'b0;
                            if (fail_reg[i] != shw_pkg::FAIL_MAX)
                            begin
                                fail_next[i] = fail_reg[i] + 8'd1;
                            end
                            any_bad = 1'b1;
                            if (fail_next[i] > cfg.fail_limit)
                            begin
                                critical = 1'b1;
                            end
                        end
                        else
                        begin
                            healthy_next[i] = 1'b1;
                            fail_next[i]    = '0;
                        end
                    end
                end
                if (critical)
                begin
                    do_trigger = (state_next != shw_pkg::ST_ESTOP);
                end
                else if (any_bad)
                begin
                    if (state_next == shw_pkg::ST_HEALTHY)
                    begin
                        state_next = shw_pkg::ST_DEGRADED;
                    end
                end
                else if (state_next == shw_pkg::ST_DEGRADED)
                begin
                    state_next = shw_pkg::ST_HEALTHY;
                end
            end
            shw_pkg::KIND_RECOVER:
            begin
                do_recover = 1'b1;
            end
            shw_pkg::KIND_RESET:
            begin
                state_next    = shw_pkg::ST_HEALTHY;
                attempts_next = '0;
                emerg_next    = 1'b0;
                for (int i = 0; i < shw_pkg::NUM_SENSORS; i++)
                begin
                    fail_next[i]    = '0;
                    healthy_next[i] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (do_trigger)
        begin
            state_next = shw_pkg::ST_ESTOP;
            emerg_next = 1'b1;
            pulse_next = 1'b1;
            do_recover = cfg.auto_rec;
        end

        if (do_recover)
        begin
            state_next = shw_pkg::ST_RECOVERING;
            if (attempts_next != shw_pkg::ATTEMPT_MAX)
            begin
                attempts_next = attempts_next + 16'd1;
            end
            emerg_next = 1'b0;
            for (int i = 0; i < shw_pkg::NUM_SENSORS; i++)
            begin
                fail_next[i] = '0;
            end
            armed_next    = 1'b1;
            deadline_next = now + 32'(cfg.rec_delay);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shw_pkg::ST_HEALTHY;
            for (int i = 0; i < shw_pkg::NUM_SENSORS; i++)
            begin
                seen_reg[i]    <= 1'b0;
                last_reg[i]    <= '0;
                healthy_reg[i] <= 1'b1;
                fail_reg[i]    <= '0;
            end
            attempts_reg  <= '0;
            armed_reg     <= 1'b0;
            deadline_reg  <= '0;
            emerg_reg     <= 1'b0;
            pulse_reg     <= 1'b0;
            report_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                state_reg    <= state_next;
                seen_reg     <= seen_next;
                last_reg     <= last_next;
                healthy_reg  <= healthy_next;
                fail_reg     <= fail_next;
                attempts_reg <= attempts_next;
                armed_reg    <= armed_next;
                deadline_reg <= deadline_next;
                emerg_reg    <= emerg_next;
                pulse_reg    <= pulse_next;
                report_reg   <= report_next;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign wd_state         = state_reg;
    assign emergency_active = emerg_reg;
    assign stop_pulse       = pulse_reg;
    assign health_report    = report_reg;
    assign lidar_ok         = healthy_reg[shw_pkg::SENS_LIDAR];
    assign imu_ok           = healthy_reg[shw_pkg::SENS_IMU];
    assign lidar_fail_count = fail_reg[shw_pkg::SENS_LIDAR];
    assign imu_fail_count   = fail_reg[shw_pkg::SENS_IMU];
    assign recovery_count   = attempts_reg;
    assign recovery_pending = armed_reg;

endmodule

/* rtl/sensor_health_watchdog_unit.sv */
// ----------------------------------------------------------------------------
// sensor_health_watchdog_unit
// Health watchdog for a lidar and an IMU: one timestamped event in, one
// status result out.
//
// Channel   Handshake            Content
// config    psel/penable/pready  six registers at byte address 4*index
// input     in_valid/in_ready    req_type, time_ms, accel_x/y/z
// output    out_valid/out_ready  state, flags, fail counts, recovery status
//
// One event per cycle is sustained while the output is not stalled; each result
// passes the front square stage, the queue write and the back state update.
// The squared acceleration limits are registered from the accel limit registers.
// A four-entry queue lets the front keep taking events while the output stalls.
// Reset is asynchronous and active low and restores all register defaults.
// ----------------------------------------------------------------------------
module sensor_health_watchdog_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [shw_pkg::ADDR_W-1:0]  paddr,
    input  logic [shw_pkg::DATA_W-1:0]  pwdata,
    output logic [shw_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  req_type,
    input  logic [31:0]                 time_ms,
    input  logic signed [15:0]          accel_x,
    input  logic signed [15:0]          accel_y,
    input  logic signed [15:0]          accel_z,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  wd_state,
    output logic                        emergency_active,
    output logic                        stop_pulse,
    output logic                        health_report,
    output logic                        lidar_ok,
    output logic                        imu_ok,
    output logic [7:0]                  lidar_fail_count,
    output logic [7:0]                  imu_fail_count,
    output logic [15:0]                 recovery_count,
    output logic                        recovery_pending
);

    shw_pkg::cfg_t  cfg;
    shw_pkg::item_t push_item;
    shw_pkg::item_t head_item;
    logic           q_full;
    logic           q_empty;
    logic           q_push;
    logic           q_pop;

    assign pready = 1'b1;

    shw_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    shw_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .time_ms  (time_ms),
        .accel_x  (accel_x),
        .accel_y  (accel_y),
        .accel_z  (accel_z),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    shw_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_item (head_item)
    );

    shw_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .q_empty          (q_empty),
        .q_item           (head_item),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .wd_state         (wd_state),
        .emergency_active (emergency_active),
        .stop_pulse       (stop_pulse),
        .health_report    (health_report),
        .lidar_ok         (lidar_ok),
        .imu_ok           (imu_ok),
        .lidar_fail_count (lidar_fail_count),
        .imu_fail_count   (imu_fail_count),
        .recovery_count   (recovery_count),
        .recovery_pending (recovery_pending)
    );

endmodule

/* dv/tb_sensor_health_watchdog_unit.sv */
// ----------------------------------------------------------------------------
// tb_sensor_health_watchdog_unit
// Self-checking testbench for the sensor health watchdog. Directed and random
// timestamped events enter through the input channel. A model of the watchdog
// inside the bench predicts one status transfer per event, and the monitor
// compares every field of each status transfer in order. Register settings,
// idle patterns and output stalls change from phase to phase.
// ----------------------------------------------------------------------------
module tb_sensor_health_watchdog_unit;

    localparam logic [2:0] REQ_LAST_CODE = 3'd7;

    localparam int STYLE_MIXED        = 0;
    localparam int STYLE_LIDAR_SILENT = 1;
    localparam int STYLE_STORM        = 2;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 120;

    typedef struct packed {
        logic [2:0]         req;
        logic [31:0]        t;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } wd_event_t;

    typedef struct packed {
        shw_pkg::wd_state_t state;
        logic               emergency;
        logic               stop_pulse;
        logic               report;
        logic               lidar_ok;
        logic               imu_ok;
        logic [7:0]         lidar_fails;
        logic [7:0]         imu_fails;
        logic [15:0]        attempts;
        logic               pending;
    } wd_status_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [shw_pkg::ADDR_W-1:0]   paddr = '0;
    logic [shw_pkg::DATA_W-1:0]   pwdata = '0;
    logic [shw_pkg::DATA_W-1:0]   prdata;
    logic                         pready;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [2:0]                   req_type = '0;
    logic [31:0]                  time_ms = '0;
    logic signed [15:0]           accel_x = '0;
    logic signed [15:0]           accel_y = '0;
    logic signed [15:0]           accel_z = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [2:0]                   wd_state;
    logic                         emergency_active;
    logic                         stop_pulse;
    logic                         health_report;
    logic                         lidar_ok;
    logic                         imu_ok;
    logic [7:0]                   lidar_fail_count;
    logic [7:0]                   imu_fail_count;
    logic [15:0]                  recovery_count;
    logic                         recovery_pending;

    logic [15:0] cfg_tmo   = shw_pkg::RST_TIMEOUT;
    logic [7:0]  cfg_lim   = shw_pkg::RST_FAIL_LIMIT;
    logic        cfg_auto  = shw_pkg::RST_AUTO_REC;
    logic [15:0] cfg_delay = shw_pkg::RST_REC_DELAY;
    logic [14:0] cfg_high  = shw_pkg::RST_ACCEL_HIGH;
    logic [14:0] cfg_low   = shw_pkg::RST_ACCEL_LOW;

    shw_pkg::wd_state_t mon_state = shw_pkg::ST_HEALTHY;
    logic [1:0]  snr_seen = 2'b00;
    logic [1:0]  snr_ok = 2'b11;
    logic [31:0] snr_last [shw_pkg::NUM_SENSORS] = '{default: '0};
    logic [7:0]  snr_fails [shw_pkg::NUM_SENSORS] = '{default: '0};
    logic [15:0] rec_attempts = '0;
    logic        rec_armed = 1'b0;
    logic [31:0] rec_deadline = '0;
    logic        estop_flag = 1'b0;
    logic        stop_now = 1'b0;

    logic [31:0] gen_clock = '0;
    logic [31:0] gen_last [shw_pkg::NUM_SENSORS] = '{default: '0};
    logic [31:0] gen_deadline = '0;

    wd_event_t   pending_events [$];
    wd_status_t  predicted_status [$];
    wd_event_t   next_ev;
    wd_status_t  oldest;

    logic        in_fire = 1'b0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          phase_no = 0;
    int          hold_phase = -1;
    int          hold_left = 0;
    int          queued_count = 0;
    int          taken_count = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    sensor_health_watchdog_unit uut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .time_ms          (time_ms),
        .accel_x          (accel_x),
        .accel_y          (accel_y),
        .accel_z          (accel_z),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .wd_state         (wd_state),
        .emergency_active (emergency_active),
        .stop_pulse       (stop_pulse),
        .health_report    (health_report),
        .lidar_ok         (lidar_ok),
        .imu_ok           (imu_ok),
        .lidar_fail_count (lidar_fail_count),
        .imu_fail_count   (imu_fail_count),
        .recovery_count   (recovery_count),
        .recovery_pending (recovery_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void begin_recovery(input logic [31:0] t);
        mon_state = shw_pkg::ST_RECOVERING;
        if (rec_attempts != shw_pkg::ATTEMPT_MAX)
            rec_attempts = rec_attempts + 16'd1;
        estop_flag = 1'b0;
        snr_fails[shw_pkg::SENS_LIDAR] = '0;
        snr_fails[shw_pkg::SENS_IMU] = '0;
        rec_armed = 1'b1;
        rec_deadline = t + {16'd0, cfg_delay};
    endfunction

    function automatic void raise_emergency(input logic [31:0] t);
        mon_state = shw_pkg::ST_ESTOP;
        estop_flag = 1'b1;
        stop_now = 1'b1;
        if (cfg_auto)
            begin_recovery(t);
    endfunction

    function automatic wd_status_t watchdog_step(input wd_event_t ev);
        wd_status_t         res;
        logic [31:0]        since;
        logic signed [31:0] sx, sy, sz;
        logic [31:0]        px, py, pz;
        logic [33:0]        mag_sq, hi_sq, lo_sq;
        logic               any_bad, critical;
        stop_now = 1'b0;
        since = ev.t - rec_deadline;
        if (rec_armed && !since[31])
        begin
            rec_armed = 1'b0;
            mon_state = (snr_ok == 2'b11) ? shw_pkg::ST_HEALTHY : shw_pkg::ST_FAULT;
        end
        case (ev.req)
            shw_pkg::REQ_LIDAR:
            begin
                snr_seen[shw_pkg::SENS_LIDAR] = 1'b1;
                snr_last[shw_pkg::SENS_LIDAR] = ev.t;
                snr_ok[shw_pkg::SENS_LIDAR] = 1'b1;
            end
            shw_pkg::REQ_IMU:
            begin
                sx = 32'(ev.ax);
                sy = 32'(ev.ay);
                sz = 32'(ev.az);
                px = sx * sx;
                py = sy * sy;
                pz = sz * sz;
                mag_sq = {2'b00, px} + {2'b00, py} + {2'b00, pz};
                hi_sq = {19'd0, cfg_high} * {19'd0, cfg_high};
                lo_sq = {19'd0, cfg_low} * {19'd0, cfg_low};
                snr_seen[shw_pkg::SENS_IMU] = 1'b1;
                snr_last[shw_pkg::SENS_IMU] = ev.t;
                snr_ok[shw_pkg::SENS_IMU] = 1'b1;
                if (mag_sq > hi_sq || mag_sq < lo_sq)
                    raise_emergency(ev.t);
            end
            shw_pkg::REQ_CHECK:
            begin
                any_bad = 1'b0;
                critical = 1'b0;
                for (int i = 0; i < shw_pkg::NUM_SENSORS; i++)
                begin
                    if (snr_seen[i])
                    begin
                        since = ev.t - snr_last[i];
                        if (since > {16'd0, cfg_tmo})
                        begin
                            snr_ok[i] = 1'b0;
                            if (snr_fails[i] != shw_pkg::FAIL_MAX)
                                snr_fails[i] = snr_fails[i] + 8'd1;
                            any_bad = 1'b1;
                            if (snr_fails[i] > cfg_lim)
                                critical = 1'b1;
                        end
                        else
                        begin
                            snr_ok[i] = 1'b1;
                            snr_fails[i] = '0;
                        end
                    end
                end
                if (critical)
                begin
                    if (mon_state != shw_pkg::ST_ESTOP)
                        raise_emergency(ev.t);
                end
                else if (any_bad)
                begin
                    if (mon_state == shw_pkg::ST_HEALTHY)
                        mon_state = shw_pkg::ST_DEGRADED;
                end
                else if (mon_state == shw_pkg::ST_DEGRADED)
                    mon_state = shw_pkg::ST_HEALTHY;
            end
            shw_pkg::REQ_RECOVER:
                begin_recovery(ev.t);
            shw_pkg::REQ_RESET:
            begin
                mon_state = shw_pkg::ST_HEALTHY;
                rec_attempts = '0;
                snr_fails[shw_pkg::SENS_LIDAR] = '0;
                snr_fails[shw_pkg::SENS_IMU] = '0;
                snr_ok = 2'b11;
                estop_flag = 1'b0;
            end
            default:
                ;
        endcase
        res.state = mon_state;
        res.emergency = estop_flag;
        res.stop_pulse = stop_now;
        res.report = (ev.req == shw_pkg::REQ_CHECK);
        res.lidar_ok = snr_ok[shw_pkg::SENS_LIDAR];
        res.imu_ok = snr_ok[shw_pkg::SENS_IMU];
        res.lidar_fails = snr_fails[shw_pkg::SENS_LIDAR];
        res.imu_fails = snr_fails[shw_pkg::SENS_IMU];
        res.attempts = rec_attempts;
        res.pending = rec_armed;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (predicted_status.size() == 0)
                begin
                    $display("%0t: status transfer with none expected, actual state %0d",
                             $time, wd_state);
                    mismatches++;
                end
                else
                begin
                    oldest = predicted_status.pop_front();
                    check_field("wd_state", 16'(oldest.state), 16'(wd_state));
                    check_field("emergency_active", 16'(oldest.emergency),
                                16'(emergency_active));
                    check_field("stop_pulse", 16'(oldest.stop_pulse), 16'(stop_pulse));
                    check_field("health_report", 16'(oldest.report), 16'(health_report));
                    check_field("lidar_ok", 16'(oldest.lidar_ok), 16'(lidar_ok));
                    check_field("imu_ok", 16'(oldest.imu_ok), 16'(imu_ok));
                    check_field("lidar_fail_count", 16'(oldest.lidar_fails),
                                16'(lidar_fail_count));
                    check_field("imu_fail_count", 16'(oldest.imu_fails),
                                16'(imu_fail_count));
                    check_field("recovery_count", oldest.attempts, recovery_count);
                    check_field("recovery_pending", 16'(oldest.pending),
                                16'(recovery_pending));
                end
            end
            if (in_valid && in_ready)
            begin
                predicted_status.push_back(watchdog_step({req_type, time_ms,
                                                          accel_x, accel_y, accel_z}));
                taken_count++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_ev = pending_events.pop_front();
                req_type <= next_ev.req;
                time_ms <= next_ev.t;
                accel_x <= next_ev.ax;
                accel_y <= next_ev.ay;
                accel_z <= next_ev.az;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (send_idle_pct == 0 && recv_idle_pct == 0 && hold_phase != phase_no
                     && out_valid)
            begin
                out_ready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_phase <= phase_no;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            shw_pkg::REG_TIMEOUT:    cfg_tmo = val[15:0];
            shw_pkg::REG_FAIL_LIMIT: cfg_lim = val[7:0];
            shw_pkg::REG_AUTO_REC:   cfg_auto = val[0];
            shw_pkg::REG_REC_DELAY:  cfg_delay = val[15:0];
            shw_pkg::REG_ACCEL_HIGH: cfg_high = val[14:0];
            shw_pkg::REG_ACCEL_LOW:  cfg_low = val[14:0];
            default:                 ;
        endcase
    endtask

    task automatic configure(input logic [15:0] tmo, input logic [7:0] lim,
                             input logic auto_on, input logic [15:0] dly,
                             input logic [14:0] hi, input logic [14:0] lo);
        write_reg(shw_pkg::REG_TIMEOUT, {16'd0, tmo});
        write_reg(shw_pkg::REG_FAIL_LIMIT, {24'd0, lim});
        write_reg(shw_pkg::REG_AUTO_REC, {31'd0, auto_on});
        write_reg(shw_pkg::REG_REC_DELAY, {16'd0, dly});
        write_reg(shw_pkg::REG_ACCEL_HIGH, {17'd0, hi});
        write_reg(shw_pkg::REG_ACCEL_LOW, {17'd0, lo});
        repeat (2) @(negedge clk);
    endtask

    task automatic queue_event(input logic [2:0] req, input logic [31:0] t,
                               input logic signed [15:0] ax, input logic signed [15:0] ay,
                               input logic signed [15:0] az);
        while (pending_events.size() >= 4)
            @(posedge clk);
        pending_events.push_back({req, t, ax, ay, az});
        queued_count++;
        gen_clock = t;
        if (req == shw_pkg::REQ_LIDAR)
            gen_last[shw_pkg::SENS_LIDAR] = t;
        else if (req == shw_pkg::REQ_IMU)
            gen_last[shw_pkg::SENS_IMU] = t;
        else if (req == shw_pkg::REQ_RECOVER)
            gen_deadline = t + {16'd0, cfg_delay};
    endtask

    function automatic logic [31:0] next_ms(input logic is_check);
        int unsigned pick;
        int unsigned tmo;
        int unsigned dly;
        pick = $urandom_range(0, 99);
        tmo = 32'(cfg_tmo);
        dly = 32'(cfg_delay);
        if (pick < 45)
            gen_clock = gen_clock + $urandom_range(0, tmo / 4 + 1);
        else if (pick < 68)
            gen_clock = gen_clock + $urandom_range(tmo / 2, tmo + tmo / 4 + 2);
        else if (pick < 80 && is_check)
            gen_clock = gen_last[$urandom_range(0, 1)] + tmo + $urandom_range(0, 1);
        else if (pick < 88)
            gen_clock = gen_clock + $urandom_range(0, dly + 2);
        else if (pick < 93)
            gen_clock = gen_deadline + $urandom_range(0, 1) - 1;
        else if (pick < 98)
            gen_clock = gen_clock + $urandom_range(0, 32'h000F_FFFF);
        else
            gen_clock = $urandom;
        return gen_clock;
    endfunction

    task automatic random_event(input int style);
        int unsigned        pick;
        int unsigned        axis;
        int                 mag;
        logic [2:0]         req;
        logic [31:0]        t;
        logic signed [15:0] comp [3];
        comp[0] = '0;
        comp[1] = '0;
        comp[2] = '0;
        if (style == STYLE_STORM)
        begin
            req = shw_pkg::REQ_RECOVER;
            t = gen_clock + $urandom_range(0, 3);
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (style == STYLE_LIDAR_SILENT)
                req = (pick < 12) ? shw_pkg::REQ_IMU : shw_pkg::REQ_CHECK;
            else if (pick < 22)
                req = shw_pkg::REQ_LIDAR;
            else if (pick < 44)
                req = shw_pkg::REQ_IMU;
            else if (pick < 80)
                req = shw_pkg::REQ_CHECK;
            else if (pick < 87)
                req = shw_pkg::REQ_RECOVER;
            else if (pick < 93)
                req = shw_pkg::REQ_RESET;
            else
                req = 3'($urandom_range(shw_pkg::REQ_RESET + 1, REQ_LAST_CODE));
            t = next_ms(req == shw_pkg::REQ_CHECK);
        end
        if (req == shw_pkg::REQ_IMU)
        begin
            pick = (style == STYLE_LIDAR_SILENT) ? 0 : $urandom_range(0, 99);
            axis = $urandom_range(0, 2);
            if (pick < 55)
            begin
                mag = (cfg_low <= cfg_high) ? $urandom_range(cfg_low, cfg_high)
                                            : $urandom_range(0, 32767);
                comp[axis] = 16'($urandom_range(0, 1) ? -mag : mag);
            end
            else if (pick < 70)
            begin
                mag = ($urandom_range(0, 1) ? cfg_high : cfg_low) + $urandom_range(0, 2) - 1;
                if (mag > 32767)
                    mag = 32767;
                if (mag < 0)
                    mag = 0;
                comp[axis] = 16'($urandom_range(0, 1) ? -mag : mag);
            end
            else if (pick < 85)
            begin
                comp[0] = 16'($urandom);
                comp[1] = 16'($urandom);
                comp[2] = 16'($urandom);
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    case ($urandom_range(0, 3))
                        0:       comp[k] = 16'sh8000;
                        1:       comp[k] = 16'sh7FFF;
                        2:       comp[k] = 16'sh0000;
                        default: comp[k] = 16'shFFFF;
                    endcase
                end
            end
        end
        queue_event(req, t, comp[0], comp[1], comp[2]);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int count,
                             input int style);
        phase_no++;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
            random_event(style);
        while (taken_count != queued_count || predicted_status.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        send_idle_pct = 17;
        recv_idle_pct = 86;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_event(shw_pkg::REQ_CHECK, 32'd0, 16'sd0, 16'sd0, 16'sd0);
        queue_event(shw_pkg::REQ_LIDAR, 32'd10, 16'sd0, 16'sd0, 16'sd0);
        queue_event(shw_pkg::REQ_IMU, 32'd20, 16'sd0, 16'sd0, 16'sd2509);
        queue_event(shw_pkg::REQ_IMU, 32'd30, 16'sd6400, 16'sd0, 16'sd0);
        queue_event(shw_pkg::REQ_IMU, 32'd40, 16'sd6401, 16'sd0, 16'sd0);
        queue_event(shw_pkg::REQ_IMU, 32'd50, 16'sd0, 16'sd1280, 16'sd0);
        queue_event(shw_pkg::REQ_IMU, 32'd60, 16'sd0, 16'sd0, 16'sd1279);
        queue_event(shw_pkg::REQ_CHECK, 32'd1010, 16'sd0, 16'sd0, 16'sd0);
        queue_event(shw_pkg::REQ_CHECK, 32'd1011, 16'sd0, 16'sd0, 16'sd0);
        queue_event(shw_pkg::REQ_IMU, 32'd1020, 16'sh8000, 16'sh8000, 16'sh8000);
        queue_event(shw_pkg::REQ_IMU, 32'd1021, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        queue_event(shw_pkg::REQ_CHECK, 32'd4020, 16'sd0, 16'sd0, 16'sd0);
        queue_event(shw_pkg::REQ_CHECK, 32'd4021, 16'sd0, 16'sd0, 16'sd0);
        queue_event(shw_pkg::REQ_CHECK, 32'd4022, 16'sd0, 16'sd0, 16'sd0);
        queue_event(shw_pkg::REQ_CHECK, 32'd4023, 16'sd0, 16'sd0, 16'sd0);
        queue_event(shw_pkg::REQ_CHECK, 32'd4024, 16'sd0, 16'sd0, 16'sd0);
        queue_event(shw_pkg::REQ_RESET + 3'd1, 32'd4030, 16'sd0, 16'sd0, 16'sd0);
        queue_event(REQ_LAST_CODE - 3'd1, 32'd4031, 16'sd0, 16'sd0, 16'sd0);
        queue_event(REQ_LAST_CODE, 32'd4032, 16'sd0, 16'sd0, 16'sd0);
        queue_event(shw_pkg::REQ_RECOVER, 32'd4040, 16'sd0, 16'sd0, 16'sd0);
        queue_event(shw_pkg::REQ_RESET, 32'd4050, 16'sd0, 16'sd0, 16'sd0);
        queue_event(shw_pkg::REQ_IMU, 32'd4060, 16'sd0, 16'sd0, 16'sd0);
        queue_event(shw_pkg::REQ_LIDAR, 32'hFFFF_FFF0, 16'sd0, 16'sd0, 16'sd0);
        queue_event(shw_pkg::REQ_LIDAR, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 16'sd0);
        queue_event(shw_pkg::REQ_CHECK, 32'h0000_0100, 16'sd0, 16'sd0, 16'sd0);

        run_phase(17, 86, 200, STYLE_MIXED);
        configure(16'd1, 8'd0, 1'b0, 16'd1, 15'd32767, 15'd0);
        run_phase(86, 17, 200, STYLE_MIXED);
        configure(16'd65535, 8'd255, 1'b1, 16'd65535, 15'd0, 15'd32767);
        run_phase(0, 0, 200, STYLE_MIXED);
        configure(16'd500, 8'd255, 1'b0, 16'd2000, 15'd6400, 15'd1280);
        run_phase(17, 86, 400, STYLE_LIDAR_SILENT);
        configure(16'($urandom_range(10, 1500)), 8'($urandom_range(0, 6)),
                  1'($urandom_range(0, 1)), 16'($urandom_range(1, 4000)),
                  15'($urandom_range(2000, 9000)), 15'($urandom_range(0, 2500)));
        run_phase(86, 17, 200, STYLE_MIXED);
        configure(16'd50, 8'd2, 1'b1, 16'd100, 15'd3000, 15'd2000);
        run_phase(0, 0, 300, STYLE_MIXED);
        run_phase(0, 0, 60, STYLE_STORM);
        configure(16'($urandom_range(10, 1500)), 8'($urandom_range(0, 6)),
                  1'($urandom_range(0, 1)), 16'($urandom_range(1, 4000)),
                  15'($urandom_range(2000, 9000)), 15'($urandom_range(0, 2500)));
        run_phase(17, 86, 250, STYLE_MIXED);
        configure(16'($urandom_range(1, 300)), 8'($urandom_range(0, 6)),
                  1'($urandom_range(0, 1)), 16'($urandom_range(1, 600)),
                  15'($urandom_range(2000, 9000)), 15'($urandom_range(0, 2500)));
        run_phase(86, 17, 200, STYLE_MIXED);
        configure(16'($urandom_range(10, 1500)), 8'($urandom_range(0, 6)), 1'b1,
                  16'($urandom_range(1, 4000)), 15'($urandom_range(2000, 9000)),
                  15'($urandom_range(0, 2500)));
        run_phase(0, 0, 200, STYLE_MIXED);

        repeat (8) @(posedge clk);
        if (mismatches == 0 && predicted_status.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sensor_health_watchdog_unit.f */
rtl/shw_pkg.sv
rtl/shw_regs.sv
rtl/shw_front.sv
rtl/shw_queue.sv
rtl/shw_back.sv
rtl/sensor_health_watchdog_unit.sv
dv/tb_sensor_health_watchdog_unit.sv
